// ----- design/bitmap_first_fit_allocator_assert.svh -----
// Assertion helpers for the checker module bffa_chk.
`ifndef BITMAP_FIRST_FIT_ALLOCATOR_ASSERT_SVH
`define BITMAP_FIRST_FIT_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, held off while reset is low.
`define BFFA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bffa assertion failed");

// Next-cycle implication, held off while reset is low.
`define BFFA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bffa assertion failed");

`endif

// ----- design/bffa_pkg.sv -----
package bffa_pkg;

    localparam int MAP_BITS   = 1024;
    localparam int WORD_BITS  = 32;
    localparam int NUM_CELLS  = MAP_BITS / WORD_BITS;

    localparam int IDX_W      = $clog2(MAP_BITS);
    localparam int LEN_W      = IDX_W + 1;
    localparam int END_W      = IDX_W + 2;
    localparam int WORD_SEL_W = $clog2(WORD_BITS);
    localparam int OFF_W      = WORD_SEL_W + 1;
    localparam int CELL_W     = $clog2(NUM_CELLS);
    localparam int REQ_W      = 2;

    localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ALLOC  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FREE   = 2'd2;

    // Request travelling down the row of cells.
    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic [IDX_W-1:0] first;
        logic [END_W-1:0] last_excl;
        logic [LEN_W-1:0] want;
        logic [LEN_W-1:0] run;
        logic             found;
        logic [IDX_W-1:0] index;
    } t_token;

endpackage

// ----- design/bffa_if.sv -----
interface bffa_req_if import bffa_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [REQ_W-1:0] req_type;
    logic [IDX_W-1:0] first_index;
    logic [LEN_W-1:0] run_length;

    modport source (output valid, req_type, first_index, run_length, input ready);
    modport sink   (input valid, req_type, first_index, run_length, output ready);
endinterface

interface bffa_rsp_if import bffa_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             status;
    logic [IDX_W-1:0] found_index;

    modport source (output valid, status, found_index, input ready);
    modport sink   (input valid, status, found_index, output ready);
endinterface

// ----- design/bffa_cell.sv -----
module bffa_cell import bffa_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [CELL_W-1:0] i_cell_idx,
    input  logic              i_tok_vld,
    input  t_token            i_tok,
    output logic              o_tok_vld,
    output t_token            o_tok
);

    logic [WORD_BITS-1:0] r_word, n_word;
    logic                 r_tok_vld;
    t_token               r_tok, n_tok;

    logic [IDX_W-1:0]     base;
    logic [END_W-1:0]     base_e, top_e, first_e, found_e;
    logic [OFF_W-1:0]     lo, hi;
    logic [WORD_BITS:0]   ones, span;
    logic [WORD_BITS-1:0] mask;

    // last set bit at or below each position, built as a prefix scan
    logic                  lv_has [0:WORD_SEL_W][0:WORD_BITS-1];
    logic [WORD_SEL_W-1:0] lv_pos [0:WORD_SEL_W][0:WORD_BITS-1];
    logic [LEN_W-1:0]      run_at [0:WORD_BITS-1];
    logic                  hit_any;
    logic [WORD_SEL_W-1:0] hit_pos;
    logic                  search_act;

    always_comb begin
        base    = {i_cell_idx, WORD_SEL_W'(0)};
        base_e  = END_W'(base);
        top_e   = base_e + END_W'(WORD_BITS);
        first_e = END_W'(i_tok.first);

        if (first_e <= base_e) begin
            lo = '0;
        end else if (first_e >= top_e) begin
            lo = OFF_W'(WORD_BITS);
        end else begin
            lo = OFF_W'(first_e - base_e);
        end
        if (i_tok.last_excl <= base_e) begin
            hi = '0;
        end else if (i_tok.last_excl >= top_e) begin
            hi = OFF_W'(WORD_BITS);
        end else begin
            hi = OFF_W'(i_tok.last_excl - base_e);
        end
        ones = '1;
        span = (ones << lo) & ~(ones << hi);
        mask = span[WORD_BITS-1:0];
    end

    always_comb begin
        for (int j = 0; j < WORD_BITS; j++) begin
            lv_has[0][j] = r_word[j];
            lv_pos[0][j] = WORD_SEL_W'(j);
        end
        for (int d = 0; d < WORD_SEL_W; d++) begin
            for (int j = 0; j < WORD_BITS; j++) begin
                if (j >= (1 << d) && !lv_has[d][j]) begin
                    lv_has[d+1][j] = lv_has[d][j - (1 << d)];
                    lv_pos[d+1][j] = lv_pos[d][j - (1 << d)];
                end else begin
                    lv_has[d+1][j] = lv_has[d][j];
                    lv_pos[d+1][j] = lv_pos[d][j];
                end
            end
        end
        // zero run ending at each bit, counting the run carried in
        for (int j = 0; j < WORD_BITS; j++) begin
            if (lv_has[WORD_SEL_W][j]) begin
                run_at[j] = LEN_W'(j) - LEN_W'(lv_pos[WORD_SEL_W][j]);
            end else begin
                run_at[j] = i_tok.run + LEN_W'(j + 1);
            end
        end
        hit_any = 1'b0;
        hit_pos = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--) begin
            if (run_at[j] >= i_tok.want) begin
                hit_any = 1'b1;
                hit_pos = WORD_SEL_W'(j);
            end
        end
        found_e = base_e + END_W'(hit_pos) + END_W'(1) - END_W'(i_tok.want);
    end

    always_comb begin
        search_act = (i_tok.req == REQ_SEARCH) && (i_tok.want != '0) && !i_tok.found;
        n_tok  = i_tok;
        n_word = r_word;
        if (i_tok_vld) begin
            if (search_act) begin
                n_tok.run = run_at[WORD_BITS-1];
                if (hit_any) begin
                    n_tok.found = 1'b1;
                    n_tok.index = found_e[IDX_W-1:0];
                end
            end
            if (i_tok.req == REQ_ALLOC) begin
                n_word = r_word | mask;
            end else if (i_tok.req == REQ_FREE) begin
                n_word = r_word & ~mask;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word    <= '0;
            r_tok_vld <= 1'b0;
        end else begin
            r_word    <= n_word;
            r_tok_vld <= i_tok_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok <= n_tok;
    end

    assign o_tok_vld = r_tok_vld;
    assign o_tok     = r_tok;

endmodule

// ----- design/bitmap_first_fit_allocator.sv -----
// Bitmap first-fit allocator: one allocation bit per unit, all free after reset.
// i_req carries a word {req_type, first_index, run_length}: search for the
// first free run of run_length bits, allocate a range, or free a range.
// o_rsp returns one word {status, found_index} per request; status 1 means
// no free run was found (found_index is then 0). Marks echo first_index.
// The map is held in a row of 32 cells of 32 bits each; a request walks the
// row one cell per cycle, and as it leaves the last cell its result is
// registered; when the output register is free, i_req.ready rises with o_rsp.valid.
// Only one request is in the row at a time.
// A result that the receiver stalls waits in the output register; a second
// result parks in a skid register and i_req.ready stays low until it drains.
// Synchronous reset clears the whole map and drops any request in flight.
module bitmap_first_fit_allocator import bffa_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bffa_req_if.sink    i_req,
    bffa_rsp_if.source  o_rsp
);

    logic             tok_vld [0:NUM_CELLS];
    t_token           tok     [0:NUM_CELLS];
    logic             accept, exit_vld, pop;
    logic             exit_status;
    logic [IDX_W-1:0] exit_idx;

    logic             r_busy, n_busy;
    logic             r_out_vld, n_out_vld, r_out_status, n_out_status;
    logic [IDX_W-1:0] r_out_idx, n_out_idx;
    logic             r_skid_vld, n_skid_vld, r_skid_status, n_skid_status;
    logic [IDX_W-1:0] r_skid_idx, n_skid_idx;

    assign i_req.ready = !r_busy && !r_skid_vld;
    assign accept      = i_req.valid && i_req.ready;

    always_comb begin
        tok_vld[0]       = accept;
        tok[0].req       = i_req.req_type;
        tok[0].first     = i_req.first_index;
        tok[0].last_excl = END_W'(i_req.first_index) + END_W'(i_req.run_length);
        tok[0].want      = i_req.run_length;
        tok[0].run       = '0;
        tok[0].found     = 1'b0;
        tok[0].index     = '0;
    end

    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        bffa_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cell_idx (CELL_W'(k)),
            .i_tok_vld  (tok_vld[k]),
            .i_tok      (tok[k]),
            .o_tok_vld  (tok_vld[k+1]),
            .o_tok      (tok[k+1])
        );
    end

    always_comb begin
        exit_vld = tok_vld[NUM_CELLS];
        if (tok[NUM_CELLS].req == REQ_SEARCH) begin
            exit_status = !tok[NUM_CELLS].found;
            exit_idx    = tok[NUM_CELLS].found ? tok[NUM_CELLS].index : '0;
        end else begin
            exit_status = 1'b0;
            exit_idx    = tok[NUM_CELLS].first;
        end
    end

    assign pop = r_out_vld && o_rsp.ready;

    always_comb begin
        n_busy        = r_busy;
        n_out_vld     = r_out_vld;
        n_out_status  = r_out_status;
        n_out_idx     = r_out_idx;
        n_skid_vld    = r_skid_vld;
        n_skid_status = r_skid_status;
        n_skid_idx    = r_skid_idx;

        if (accept) begin
            n_busy = 1'b1;
        end else if (exit_vld) begin
            n_busy = 1'b0;
        end

        if (r_skid_vld && (pop || !r_out_vld)) begin
            n_out_vld    = 1'b1;
            n_out_status = r_skid_status;
            n_out_idx    = r_skid_idx;
            n_skid_vld   = 1'b0;
        end else if (exit_vld && (pop || !r_out_vld)) begin
            n_out_vld    = 1'b1;
            n_out_status = exit_status;
            n_out_idx    = exit_idx;
        end else if (exit_vld) begin
            n_skid_vld    = 1'b1;
            n_skid_status = exit_status;
            n_skid_idx    = exit_idx;
        end else if (pop) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            r_busy     <= n_busy;
            r_out_vld  <= n_out_vld;
            r_skid_vld <= n_skid_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_status  <= n_out_status;
        r_out_idx     <= n_out_idx;
        r_skid_status <= n_skid_status;
        r_skid_idx    <= n_skid_idx;
    end

    assign o_rsp.valid       = r_out_vld;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.found_index = r_out_idx;

endmodule

// ----- design/bffa_chk.sv -----
`include "bitmap_first_fit_allocator_assert.svh"

module bffa_chk import bffa_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic             i_out_status,
    input logic [IDX_W-1:0] i_out_found_index
);

    // one request in flight: ready drops right after an accept
    `BFFA_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)
    // a miss always reports index zero
    `BFFA_ASSERT_NOW(a_miss_idx_zero, i_clk, i_rst_n, i_out_valid && i_out_status, i_out_found_index == '0)
    `BFFA_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    `BFFA_ASSERT_NXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_out_status) && $stable(i_out_found_index))

endmodule

bind bitmap_first_fit_allocator bffa_chk u_bffa_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_req.valid),
    .i_in_ready        (i_req.ready),
    .i_out_valid       (o_rsp.valid),
    .i_out_ready       (o_rsp.ready),
    .i_out_status      (o_rsp.status),
    .i_out_found_index (o_rsp.found_index)
);

// ----- tb/bffa_checker.sv -----
`timescale 1ns / 1ps

// Watches both channels, keeps a shadow of the allocation map and checks every
// response word against the prediction made when the request word was taken.
module bffa_checker import bffa_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    bffa_req_if  i_req,
    bffa_rsp_if  i_rsp,
    output int   o_fail_count,
    output int   o_outstanding
);

    typedef struct packed {
        logic             status;
        logic [IDX_W-1:0] index;
    } alloc_result_t;

    logic [MAP_BITS-1:0] shadow_map;
    alloc_result_t       pending_results[$];

    initial begin
        o_fail_count  = 0;
        o_outstanding = 0;
        shadow_map    = '0;
    end

    task automatic report_mismatch(input string msg);
        o_fail_count++;
        $display("bffa check @%0t: %s", $realtime, msg);
    endtask

    // First-fit search: the run must reach exactly the wanted length.
    function automatic alloc_result_t find_first_fit(input logic [LEN_W-1:0] want);
        alloc_result_t res;
        int            run_len;
        int            run_start;
        res       = '{status: 1'b1, index: '0};
        run_len   = 0;
        run_start = 0;
        if (want == 0)
            return res;
        for (int i = 0; i < MAP_BITS; i++) begin
            if (!shadow_map[i]) begin
                run_len++;
                if (run_len == int'(want)) begin
                    res.status = 1'b0;
                    res.index  = run_start[IDX_W-1:0];
                    return res;
                end
            end else begin
                run_len   = 0;
                run_start = i + 1;
            end
        end
        return res;
    endfunction

    // Bits past the end of the map are dropped.
    function automatic void mark_bits(input logic [IDX_W-1:0] first,
                                      input logic [LEN_W-1:0] count, input logic value);
        for (int i = int'(first); i < int'(first) + int'(count) && i < MAP_BITS; i++)
            shadow_map[i] = value;
    endfunction

    function automatic alloc_result_t predict_allocation(input logic [REQ_W-1:0] kind,
                                                          input logic [IDX_W-1:0] first,
                                                          input logic [LEN_W-1:0] count);
        alloc_result_t res;
        res = '{status: 1'b0, index: first};
        case (kind)
            REQ_SEARCH: res = find_first_fit(count);
            REQ_ALLOC:  mark_bits(first, count, 1'b1);
            REQ_FREE:   mark_bits(first, count, 1'b0);
            default: ;  // unused kind: map untouched, echo
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        alloc_result_t want;
        if (!i_rst_n) begin
            shadow_map = '0;
            pending_results.delete();
        end else begin
            // response side first: it can only belong to an older word
            if (i_rsp.valid && i_rsp.ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected word status=%0b index=%0d",
                                              i_rsp.status, i_rsp.found_index));
                end else begin
                    want = pending_results.pop_front();
                    if (i_rsp.status !== want.status)
                        report_mismatch($sformatf("status %0b, want %0b",
                                                  i_rsp.status, want.status));
                    if (i_rsp.found_index !== want.index)
                        report_mismatch($sformatf("found_index %0d, want %0d",
                                                  i_rsp.found_index, want.index));
                end
            end
            if (i_req.valid && i_req.ready)
                pending_results.push_back(predict_allocation(i_req.req_type,
                                                             i_req.first_index,
                                                             i_req.run_length));
        end
        o_outstanding = pending_results.size();
    end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import bffa_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int RANDOM_WORDS = 1250;
    localparam int CALM_WORDS   = 150;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        logic [IDX_W-1:0] first;
        logic [LEN_W-1:0] count;
    } held_range_t;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   outstanding;
    bit   calm;

    held_range_t held_ranges[$];

    bffa_req_if req_if ();
    bffa_rsp_if rsp_if ();

    bitmap_first_fit_allocator u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    bffa_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req_if),
        .i_rsp         (rsp_if),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    initial begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

    // Response side back-pressure in bursts; no new burst starts once the run goes calm.
    initial begin
        int stall_left;
        stall_left   = 0;
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                rsp_if.ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 19) == 0) begin
                stall_left = $urandom_range(1, 17) - 1;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the accept
    // with valid still high so back-to-back words need no extra assignment.
    task automatic send_word(input logic [REQ_W-1:0] kind, input logic [IDX_W-1:0] first,
                             input logic [LEN_W-1:0] count);
        req_if.valid       <= 1'b1;
        req_if.req_type    <= kind;
        req_if.first_index <= first;
        req_if.run_length  <= count;
        do
            @(posedge i_clk);
        while (!(req_if.valid && req_if.ready));
        @(negedge i_clk);
    endtask

    task automatic idle_sender(input int cycles);
        req_if.valid <= 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    task automatic wait_all_returned();
        req_if.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge i_clk);
    endtask

    // Mostly short runs; now and then anything the field holds.
    function automatic logic [LEN_W-1:0] pick_length(input int typical_max);
        if ($urandom_range(0, 15) == 0)
            return LEN_W'($urandom_range(0, 2047));
        return LEN_W'($urandom_range(1, typical_max));
    endfunction

    task automatic random_word();
        held_range_t rng;
        int          pick;
        int          slot;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            send_word(REQ_SEARCH, IDX_W'($urandom), pick_length(96));
        end else if (pick < 65) begin
            rng.first = IDX_W'($urandom_range(0, MAP_BITS - 1));
            rng.count = pick_length(48);
            held_ranges.push_back(rng);
            send_word(REQ_ALLOC, rng.first, rng.count);
        end else if (pick < 85 && held_ranges.size() > 0) begin
            slot = $urandom_range(0, held_ranges.size() - 1);
            rng  = held_ranges[slot];
            held_ranges.delete(slot);
            send_word(REQ_FREE, rng.first, rng.count);
        end else if (pick < 95) begin
            send_word(REQ_FREE, IDX_W'($urandom_range(0, MAP_BITS - 1)), pick_length(48));
        end else begin
            send_word(REQ_UNUSED, IDX_W'($urandom), LEN_W'($urandom));
        end
    endtask

    initial begin
        calm               = 1'b0;
        i_rst_n            = 1'b0;
        req_if.valid       = 1'b0;
        req_if.req_type    = REQ_SEARCH;
        req_if.first_index = '0;
        req_if.run_length  = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed corners
        send_word(REQ_SEARCH, 10'd0,    11'd0);     // zero length: never found
        send_word(REQ_SEARCH, 10'd1023, 11'd1);
        send_word(REQ_SEARCH, 10'd0,    11'd1024);  // whole map free
        send_word(REQ_SEARCH, 10'd0,    11'd2047);  // longer than the map
        send_word(REQ_ALLOC,  10'd0,    11'd1);
        send_word(REQ_SEARCH, 10'd0,    11'd1);
        send_word(REQ_ALLOC,  10'd1023, 11'd2047);  // runs past the end
        send_word(REQ_SEARCH, 10'd0,    11'd1023);
        send_word(REQ_SEARCH, 10'd0,    11'd1022);
        send_word(REQ_ALLOC,  10'd5,    11'd0);     // zero-length mark
        send_word(REQ_UNUSED, 10'd1023, 11'd2047);
        send_word(REQ_SEARCH, 10'd0,    11'd4);
        send_word(REQ_FREE,   10'd0,    11'd2047);
        send_word(REQ_SEARCH, 10'd0,    11'd1024);
        send_word(REQ_ALLOC,  10'd512,  11'd512);
        send_word(REQ_SEARCH, 10'd0,    11'd513);
        send_word(REQ_SEARCH, 10'd0,    11'd512);
        send_word(REQ_FREE,   10'd700,  11'd10);
        send_word(REQ_SEARCH, 10'd0,    11'd11);
        send_word(REQ_ALLOC,  10'd0,    11'd1024);
        send_word(REQ_SEARCH, 10'd0,    11'd1);
        send_word(REQ_FREE,   10'd1023, 11'd1);
        send_word(REQ_SEARCH, 10'd0,    11'd1);     // last index of the map
        send_word(REQ_FREE,   10'd0,    11'd1024);
        wait_all_returned();

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n == RANDOM_WORDS - CALM_WORDS)
                calm = 1'b1;
            if (n % 300 == 299)
                wait_all_returned();
            if (!calm && $urandom_range(0, 3) == 0)
                idle_sender($urandom_range(1, 17));
            random_word();
        end
        req_if.valid <= 1'b0;

        while (outstanding != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (fail_count == 0 && outstanding == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
